/* hdl/nonuniform_table_interpolation_top_defines.svh */
// Assertion macros shared by the interpolator's RTL
`ifndef NONUNIFORM_TABLE_INTERPOLATION_TOP_DEFINES_SVH
`define NONUNIFORM_TABLE_INTERPOLATION_TOP_DEFINES_SVH

// Same-cycle implication, reset masked
`define NTI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define NTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nti_pkg.sv */
// ----------------------------------------------------------------------------
// nti_pkg
// Request types, operation codes and divider lane type for the interpolator.
// ----------------------------------------------------------------------------
package nti_pkg;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one quotient bit per divider cell
    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic               operation;
        logic [9:0]         entry_index;
        logic signed [31:0] entry_key;
        logic signed [31:0] entry_value;
        logic signed [31:0] query_value;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               below_range;
        logic               above_range;
    } t_out_req;

    // data handed from one divider cell to the next
    typedef struct packed {
        logic        valid;
        logic [31:0] dk;
        logic [31:0] rem;
        logic [31:0] lo;
        logic [31:0] quo;
    } t_div_lane;

endpackage

/* hdl/nonuniform_table_interpolation_top.sv */
// Load: accepted while idle, no result. Query with n entries in use: the n entries are
// walked through the table's single read port; the result is registered after the walk
// when clamped or on the last key, and after a multiply, then a 32-cell divider row, when
// interpolated. One request at a time: the next is taken the cycle after the result is
// registered, later while the result is stalled.
// Reset (synchronous, active low) clears control, entries in use to 2; table undefined.
// ----------------------------------------------------------------------------
// nonuniform_table_interpolation_top
// Piecewise linear interpolation over an ascending key/value table.
// ----------------------------------------------------------------------------
`include "nonuniform_table_interpolation_top_defines.svh"

module nonuniform_table_interpolation_top
    import nti_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_req    o_out_req,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_DECIDE, S_MUL, S_LAUNCH, S_DIV, S_SUM, S_FIN
    } t_state;

    t_state             r_state;
    logic [10:0]        r_entries;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      n_n;
    logic [NW-1:0]      r_addr;
    logic [NW-1:0]      r_idx;
    logic               r_dvld;
    logic signed [31:0] r_x;
    logic signed [31:0] r_key_q, r_val_q;
    logic signed [31:0] r_prev_k, r_prev_v;
    logic signed [31:0] r_first_k, r_first_v;
    logic signed [31:0] r_last_k, r_last_v;
    logic signed [31:0] r_k1, r_k2, r_v1, r_v2;
    logic               r_match;
    logic [31:0]        r_dx, r_dk, r_mag;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [31:0]        r_quo;
    logic signed [31:0] r_res;
    logic               r_below, r_above;
    logic               r_out_vld;
    t_out_req           r_out;

    logic signed [31:0] key_mem [TABLE_DEPTH];
    logic signed [31:0] val_mem [TABLE_DEPTH];

    logic               w_in_acc;
    logic               w_slot_free;
    logic               w_idx_ok;
    logic [32:0]        w_dx, w_dk, w_dy, w_ndy;
    logic [63:0]        w_num;
    logic signed [33:0] w_sum;
    t_div_lane          w_div_in;
    t_div_lane          w_div_out;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_vld || !i_out_stall;
    assign w_idx_ok    = (32'(i_in_req.entry_index) < TABLE_DEPTH);
    assign o_cfg_ready = 1'b1;

    // entries in use, clamped to the table
    always_comb begin
        if (r_entries < 11'd2) begin
            n_n = NW'(2);
        end else if (32'(r_entries) > TABLE_DEPTH) begin
            n_n = NW'(TABLE_DEPTH);
        end else begin
            n_n = NW'(r_entries);
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= 11'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entries <= i_cfg_data;
        end
    end

    // table memories, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_req.operation == OP_LOAD && w_idx_ok) begin
            key_mem[AW'(i_in_req.entry_index)] <= i_in_req.entry_key;
            val_mem[AW'(i_in_req.entry_index)] <= i_in_req.entry_value;
        end
        r_key_q <= key_mem[r_addr[AW-1:0]];
        r_val_q <= val_mem[r_addr[AW-1:0]];
    end

    // segment differences
    always_comb begin
        w_dx  = {r_x[31], r_x} - {r_k1[31], r_k1};
        w_dk  = {r_k2[31], r_k2} - {r_k1[31], r_k1};
        w_dy  = {r_v2[31], r_v2} - {r_v1[31], r_v1};
        w_ndy = -w_dy;
        w_num = r_prod + 64'(r_dk[31:1]);
        w_sum = r_neg ? (34'(r_v1) - $signed({2'b00, r_quo}))
                      : (34'(r_v1) + $signed({2'b00, r_quo}));
    end

    // divider launch
    always_comb begin
        w_div_in.valid = (r_state == S_LAUNCH);
        w_div_in.dk    = r_dk;
        w_div_in.rem   = w_num[63:32];
        w_div_in.lo    = w_num[31:0];
        w_div_in.quo   = '0;
    end

    nti_div_chain u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_lane (w_div_in),
        .o_lane (w_div_out)
    );

    // control sequence and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dvld    <= 1'b0;
            r_out_vld <= 1'b0;
            r_match   <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_dvld <= (r_state == S_WALK) && (r_addr < r_n);
            r_idx  <= r_addr;
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in_req.operation == OP_QUERY) begin
                        r_x     <= i_in_req.query_value;
                        r_n     <= n_n;
                        r_addr  <= '0;
                        r_match <= 1'b0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_addr < r_n) begin
                        r_addr <= r_addr + NW'(1);
                    end
                    if (r_dvld) begin
                        r_prev_k <= r_key_q;
                        r_prev_v <= r_val_q;
                        if (r_idx == '0) begin
                            r_first_k <= r_key_q;
                            r_first_v <= r_val_q;
                        end else if (r_prev_k <= r_x && r_x < r_key_q) begin
                            // later segments overwrite earlier ones
                            r_k1    <= r_prev_k;
                            r_k2    <= r_key_q;
                            r_v1    <= r_prev_v;
                            r_v2    <= r_val_q;
                            r_match <= 1'b1;
                        end
                        if (r_idx == r_n - NW'(1)) begin
                            r_last_k <= r_key_q;
                            r_last_v <= r_val_q;
                            r_state  <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_dx    <= w_dx[31:0];
                    r_dk    <= w_dk[31:0];
                    r_neg   <= w_dy[32];
                    r_mag   <= w_dy[32] ? w_ndy[31:0] : w_dy[31:0];
                    r_below <= 1'b0;
                    r_above <= 1'b0;
                    r_res   <= '0;
                    r_state <= S_FIN;
                    if (r_x < r_first_k) begin
                        r_res   <= r_first_v;
                        r_below <= 1'b1;
                    end else if (r_x > r_last_k) begin
                        r_res   <= r_last_v;
                        r_above <= 1'b1;
                    end else if (r_x == r_last_k) begin
                        r_res <= r_last_v;
                    end else if (r_match) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_dx * r_mag;
                    r_state <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_out.valid) begin
                        r_quo   <= w_div_out.quo;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // saturate to 32 bits
                    if (w_sum > 34'sd2147483647) begin
                        r_res <= 32'sh7FFFFFFF;
                    end else if (w_sum < -34'sd2147483648) begin
                        r_res <= 32'sh80000000;
                    end else begin
                        r_res <= w_sum[31:0];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_slot_free) begin
                        r_out.result_value <= r_res;
                        r_out.below_range  <= r_below;
                        r_out.above_range  <= r_above;
                        r_out_vld          <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

    // checks
    `NTI_ASSERT_IMPL(a_div_only_in_div, w_div_out.valid, r_state == S_DIV, "divider output outside wait")
    `NTI_ASSERT_IMPL(a_flags_exclusive, o_out_valid, !(o_out_req.below_range && o_out_req.above_range), "both range flags set")
    `NTI_ASSERT_NEXT(a_load_no_walk, w_in_acc && i_in_req.operation == OP_LOAD, r_state == S_IDLE, "load left idle")
    `NTI_ASSERT_IMPL(a_read_in_walk, r_dvld, r_state == S_WALK, "table data outside walk")

endmodule

/* hdl/nti_div_cell.sv */
// ----------------------------------------------------------------------------
// nti_div_cell
// One restoring division step: shifts in a numerator bit, trial subtract.
// ----------------------------------------------------------------------------
module nti_div_cell
    import nti_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    logic [32:0] w_rem_s;
    logic [32:0] w_diff;
    logic        w_ge;
    t_div_lane   n_lane;
    t_div_lane   r_lane;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_rem_s      = {i_lane.rem, i_lane.lo[31]};
        w_diff       = w_rem_s - {1'b0, i_lane.dk};
        w_ge         = (w_rem_s >= {1'b0, i_lane.dk});
        n_lane.valid = i_lane.valid;
        n_lane.dk    = i_lane.dk;
        n_lane.rem   = w_ge ? w_diff[31:0] : w_rem_s[31:0];
        n_lane.lo    = {i_lane.lo[30:0], 1'b0};
        n_lane.quo   = {i_lane.quo[30:0], w_ge};
    end

    // hand on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= n_lane.valid;
        end
        r_lane.dk  <= n_lane.dk;
        r_lane.rem <= n_lane.rem;
        r_lane.lo  <= n_lane.lo;
        r_lane.quo <= n_lane.quo;
    end

    assign o_lane = r_lane;

endmodule

/* hdl/nti_div_chain.sv */
// ----------------------------------------------------------------------------
// nti_div_chain
// Row of division cells giving a 32-bit quotient of a 64-bit numerator.
// ----------------------------------------------------------------------------
module nti_div_chain
    import nti_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_lane i_lane,
    output t_div_lane o_lane
);

    t_div_lane w_lane [DIV_STEPS+1];

    assign w_lane[0] = i_lane;

    // one cell per quotient bit, MSB first
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        nti_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_lane (w_lane[g]),
            .o_lane (w_lane[g+1])
        );
    end

    assign o_lane = w_lane[DIV_STEPS];

endmodule
